// ===== rtl/rgba8_over_alpha_blend_unit_assert.svh =====
// Assertion macros for the checker of the over-blend unit.
// Each macro expects signals named clk and rst_n in the scope of its use.
`ifndef RGBA8_OVER_ALPHA_BLEND_UNIT_ASSERT_SVH
`define RGBA8_OVER_ALPHA_BLEND_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define RGBA_OB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define RGBA_OB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/rgba_ob_pkg.sv =====
`timescale 1ns / 1ps
// Package for the RGBA8 over-blend unit: pixel beat types and datapath widths.
// No dependencies; used by the top level, its checker and the bench.
package rgba_ob_pkg;

    // Full-scale channel value.
    localparam logic [7:0] CH_MAX = 8'd255;

    // Datapath sizes.
    localparam int CH_W       = 8;   // one channel
    localparam int QUO_BITS   = 8;   // quotient bits, one divider stage each
    localparam int DEN_W      = 16;  // D = sa*255 + da*(255-sa) <= 65025
    localparam int NUM_W      = 24;  // numerator <= 255 * 65025
    localparam int COLORS     = 3;   // red, green, blue

    // One input beat: a source and a destination pixel.
    typedef struct packed {
        logic [CH_W-1:0] src_red;
        logic [CH_W-1:0] src_green;
        logic [CH_W-1:0] src_blue;
        logic [CH_W-1:0] src_alpha;
        logic [CH_W-1:0] dst_red;
        logic [CH_W-1:0] dst_green;
        logic [CH_W-1:0] dst_blue;
        logic [CH_W-1:0] dst_alpha;
    } pixel_pair_t;

    // One output beat: the composited pixel.
    typedef struct packed {
        logic [CH_W-1:0] out_red;
        logic [CH_W-1:0] out_green;
        logic [CH_W-1:0] out_blue;
        logic [CH_W-1:0] out_alpha;
    } blend_pixel_t;

endpackage

// ===== rtl/rgba8_over_alpha_blend_unit.sv =====
`timescale 1ns / 1ps
// Top level of the RGBA8 over-blend unit: products, numerator and pipelined divider.
// Depends on rgba_ob_pkg.
//
// Usage:
// The pix channel takes one source/destination pixel pair per beat; the blend
// channel returns one composited pixel per beat, in the same order. Both use
// valid/ready handshakes.
// From acceptance to blend_valid, one stage forms the 8x8 products, one forms the
// numerators, the denominator D and the output alpha (D/255 by an add and shift),
// and eight stages each resolve one quotient bit for the three colors divided by
// D in parallel.
// Throughput is one pixel per clock unless the output stalls; the divider is fully
// unrolled, so a new pair may enter every cycle with earlier pairs still in flight.
// When both alphas are zero the result is forced to all zeros.
// Reset clears every stage valid bit; the pipeline comes up empty and ready.
// When the receiver holds blend_ready low with a result waiting, the whole
// pipeline holds and pix_ready drops; nothing is lost or repeated. Bubbles
// travel as cleared valid bits and never block a stage.
module rgba8_over_alpha_blend_unit (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      pix_valid,
    output logic                      pix_ready,
    input  rgba_ob_pkg::pixel_pair_t  pix,
    output logic                      blend_valid,
    input  logic                      blend_ready,
    output rgba_ob_pkg::blend_pixel_t blend
);
    import rgba_ob_pkg::*;

    localparam int TRIAL_W = NUM_W + 1;
    localparam int LAST    = QUO_BITS - 1;

    // Pipeline advance: the last stage is empty or its beat is taken.
    logic adv;

    // Input channels as arrays.
    logic [CH_W-1:0] src_col [COLORS];
    logic [CH_W-1:0] dst_col [COLORS];

    // Stage 1: products.
    logic             s1_valid_reg;
    logic             s1_zero_reg;
    logic             s1_zero_next;
    logic [CH_W-1:0]  s1_dst_reg   [COLORS];
    logic [DEN_W-1:0] s1_ps_reg    [COLORS];
    logic [DEN_W-1:0] s1_ps_next   [COLORS];
    logic [DEN_W-1:0] s1_dw_reg;
    logic [DEN_W-1:0] s1_dw_next;
    logic [DEN_W-1:0] s1_sa255_reg;
    logic [DEN_W-1:0] s1_sa255_next;

    // Stage 2: numerators, divisors and the output alpha.
    logic             s2_valid_reg;
    logic             s2_zero_reg;
    logic [DEN_W-1:0] s2_den;
    logic [DEN_W-1:0] s2_round;
    logic [CH_W-1:0]  s2_alpha_reg;
    logic [CH_W-1:0]  s2_alpha_next;
    logic [NUM_W-1:0] s2_num_reg  [COLORS];
    logic [NUM_W-1:0] s2_num_next [COLORS];
    logic [DEN_W-1:0] s2_div_reg  [COLORS];
    logic [DEN_W-1:0] s2_div_next [COLORS];

    // Divider stages, one quotient bit each.
    logic                dv_valid_reg [QUO_BITS];
    logic                dv_zero_reg  [QUO_BITS];
    logic [CH_W-1:0]     dv_alpha_reg [QUO_BITS];
    logic [NUM_W-1:0]    dv_rem_reg   [QUO_BITS][COLORS];
    logic [NUM_W-1:0]    dv_rem_next  [QUO_BITS][COLORS];
    logic [DEN_W-1:0]    dv_div_reg   [QUO_BITS][COLORS];
    logic [QUO_BITS-1:0] dv_quo_reg   [QUO_BITS][COLORS];
    logic [QUO_BITS-1:0] dv_quo_next  [QUO_BITS][COLORS];

    // Stage inputs of the divider.
    logic [NUM_W-1:0]    dv_rem_in [QUO_BITS][COLORS];
    logic [DEN_W-1:0]    dv_div_in [QUO_BITS][COLORS];
    logic [QUO_BITS-1:0] dv_quo_in [QUO_BITS][COLORS];

    assign adv       = !dv_valid_reg[LAST] || blend_ready;
    assign pix_ready = adv;

    assign src_col[0] = pix.src_red;
    assign src_col[1] = pix.src_green;
    assign src_col[2] = pix.src_blue;
    assign dst_col[0] = pix.dst_red;
    assign dst_col[1] = pix.dst_green;
    assign dst_col[2] = pix.dst_blue;

    // Stage 1 logic: s*sa per color, da*(255-sa), sa*255 by shift and subtract.
    always_comb
    begin
        for (int c = 0; c < COLORS; c++)
        begin
            s1_ps_next[c] = DEN_W'(src_col[c]) * DEN_W'(pix.src_alpha);
        end
        s1_dw_next    = DEN_W'(pix.dst_alpha) * DEN_W'(CH_MAX - pix.src_alpha);
        s1_sa255_next = {pix.src_alpha, 8'h00} - DEN_W'(pix.src_alpha);
        s1_zero_next  = (pix.src_alpha == '0) && (pix.dst_alpha == '0);
    end

    // Stage 2 logic: s*sa*255 + d*da*(255-sa) per color, D, and D/255.
    always_comb
    begin
        s2_den = s1_sa255_reg + s1_dw_reg;
        for (int c = 0; c < COLORS; c++)
        begin
            s2_num_next[c] = ({s1_ps_reg[c], 8'h00} - NUM_W'(s1_ps_reg[c]))
                           + NUM_W'(s1_dst_reg[c]) * NUM_W'(s1_dw_reg);
            s2_div_next[c] = s2_den;
        end
        // For D below 65280, D/255 equals (D + (D >> 8) + 1) >> 8; the sum fits 16 bits.
        s2_round      = s2_den + (s2_den >> 8) + DEN_W'(1);
        s2_alpha_next = s2_round[DEN_W-1:CH_W];
    end

    // Divider stage inputs: stage 0 reads stage 2, later stages their predecessor.
    always_comb
    begin
        for (int l = 0; l < COLORS; l++)
        begin
            dv_rem_in[0][l] = s2_num_reg[l];
            dv_div_in[0][l] = s2_div_reg[l];
            dv_quo_in[0][l] = '0;
        end
        for (int k = 1; k < QUO_BITS; k++)
        begin
            for (int l = 0; l < COLORS; l++)
            begin
                dv_rem_in[k][l] = dv_rem_reg[k-1][l];
                dv_div_in[k][l] = dv_div_reg[k-1][l];
                dv_quo_in[k][l] = dv_quo_reg[k-1][l];
            end
        end
    end

    // Restoring division: stage k tries to subtract the divisor shifted to
    // quotient bit (QUO_BITS-1-k). The quotient never exceeds 255.
    always_comb
    begin
        logic [TRIAL_W-1:0] trial;
        trial = '0;
        for (int k = 0; k < QUO_BITS; k++)
        begin
            for (int l = 0; l < COLORS; l++)
            begin
                trial = {1'b0, dv_rem_in[k][l]}
                      - (TRIAL_W'(dv_div_in[k][l]) << (QUO_BITS - 1 - k));
                dv_rem_next[k][l] = trial[NUM_W] ? dv_rem_in[k][l] : trial[NUM_W-1:0];
                dv_quo_next[k][l] = {dv_quo_in[k][l][QUO_BITS-2:0], !trial[NUM_W]};
            end
        end
    end

    // Valid bits, cleared at reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            for (int k = 0; k < QUO_BITS; k++)
            begin
                dv_valid_reg[k] <= 1'b0;
            end
        end
        else if (adv)
        begin
            s1_valid_reg    <= pix_valid;
            s2_valid_reg    <= s1_valid_reg;
            dv_valid_reg[0] <= s2_valid_reg;
            for (int k = 1; k < QUO_BITS; k++)
            begin
                dv_valid_reg[k] <= dv_valid_reg[k-1];
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int c = 0; c < COLORS; c++)
            begin
                s1_dst_reg[c] <= dst_col[c];
                s1_ps_reg[c]  <= s1_ps_next[c];
            end
            s1_dw_reg    <= s1_dw_next;
            s1_sa255_reg <= s1_sa255_next;
            s1_zero_reg  <= s1_zero_next;

            s2_zero_reg  <= s1_zero_reg;
            s2_alpha_reg <= s2_alpha_next;
            for (int l = 0; l < COLORS; l++)
            begin
                s2_num_reg[l] <= s2_num_next[l];
                s2_div_reg[l] <= s2_div_next[l];
            end

            dv_zero_reg[0]  <= s2_zero_reg;
            dv_alpha_reg[0] <= s2_alpha_reg;
            for (int k = 1; k < QUO_BITS; k++)
            begin
                dv_zero_reg[k]  <= dv_zero_reg[k-1];
                dv_alpha_reg[k] <= dv_alpha_reg[k-1];
            end
            for (int k = 0; k < QUO_BITS; k++)
            begin
                for (int l = 0; l < COLORS; l++)
                begin
                    dv_rem_reg[k][l] <= dv_rem_next[k][l];
                    dv_div_reg[k][l] <= dv_div_in[k][l];
                    dv_quo_reg[k][l] <= dv_quo_next[k][l];
                end
            end
        end
    end

    // Output beat; both alphas zero forces an all-zero pixel.
    assign blend_valid     = dv_valid_reg[LAST];
    assign blend.out_red   = dv_zero_reg[LAST] ? '0 : dv_quo_reg[LAST][0];
    assign blend.out_green = dv_zero_reg[LAST] ? '0 : dv_quo_reg[LAST][1];
    assign blend.out_blue  = dv_zero_reg[LAST] ? '0 : dv_quo_reg[LAST][2];
    assign blend.out_alpha = dv_zero_reg[LAST] ? '0 : dv_alpha_reg[LAST];

endmodule

// ===== rtl/rgba_ob_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the RGBA8 over-blend unit, bound to the top level.
// Depends on rgba_ob_pkg and rgba8_over_alpha_blend_unit_assert.svh.
`include "rgba8_over_alpha_blend_unit_assert.svh"

module rgba_ob_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      pix_valid,
    input logic                      pix_ready,
    input rgba_ob_pkg::pixel_pair_t  pix,
    input logic                      blend_valid,
    input logic                      blend_ready,
    input rgba_ob_pkg::blend_pixel_t blend
);
    import rgba_ob_pkg::*;

    // A stalled result beat stays put.
    `RGBA_OB_ASSERT_NEXT(a_out_hold, blend_valid && !blend_ready, blend_valid && $stable(blend), "blend beat changed while stalled")

    // A stalled output holds the whole pipeline, so no new pair may enter.
    `RGBA_OB_ASSERT_NOW(a_stall_backpressure, blend_valid && !blend_ready, !pix_ready, "pair accepted while output stalled")

    // With no result waiting, the pipeline always takes a new pair.
    `RGBA_OB_ASSERT_NOW(a_ready_when_empty, !blend_valid, pix_ready, "input blocked with output free")

    // Zero output alpha happens only when both alphas are zero, which clears all colors.
    `RGBA_OB_ASSERT_NOW(a_zero_alpha_black, blend_valid && (blend.out_alpha == '0), (blend.out_red == '0) && (blend.out_green == '0) && (blend.out_blue == '0), "colors nonzero with zero alpha")

endmodule

bind rgba8_over_alpha_blend_unit rgba_ob_checker u_rgba_ob_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .pix_valid   (pix_valid),
    .pix_ready   (pix_ready),
    .pix         (pix),
    .blend_valid (blend_valid),
    .blend_ready (blend_ready),
    .blend       (blend)
);

// ===== bench/rgba8_over_alpha_blend_unit_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the RGBA8 over-blend unit: random and directed pixel pairs,
// idling on both channels, and each composited pixel checked against a local model.
// Depends on rgba_ob_pkg and rgba8_over_alpha_blend_unit.
module rgba8_over_alpha_blend_unit_test;

    import rgba_ob_pkg::*;

    localparam int unsigned FULL_SCALE = 255;
    localparam int unsigned PHASE_ITEMS = 186;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned DRAIN_CYCLES = 20;
    localparam int unsigned WATCHDOG_CYCLES = 400_000;

    // Holds the composited pixels still owed by the block, oldest first.
    class blend_scoreboard;
        blend_pixel_t owed_pixels[$];
        int unsigned  error_count = 0;

        // One color lane: floored weighted average of source and destination.
        function automatic logic [7:0] mix_lane(int unsigned s, int unsigned d,
                                                int unsigned sa, int unsigned da,
                                                int unsigned weight_sum);
            int unsigned weighted;
            int unsigned quotient;
            weighted = s * sa * FULL_SCALE + d * da * (FULL_SCALE - sa);
            quotient = weighted / weight_sum;
            if (quotient > FULL_SCALE)
                quotient = FULL_SCALE;
            return quotient[7:0];
        endfunction

        // Over operator on non-premultiplied pixels.
        function automatic blend_pixel_t composite(pixel_pair_t p);
            blend_pixel_t r;
            int unsigned  sa;
            int unsigned  da;
            int unsigned  weight_sum;
            sa         = p.src_alpha;
            da         = p.dst_alpha;
            weight_sum = sa * FULL_SCALE + da * (FULL_SCALE - sa);
            r          = '0;
            // Fully transparent pair: the result is forced to zero.
            if (weight_sum != 0)
            begin
                r.out_red   = mix_lane(p.src_red,   p.dst_red,   sa, da, weight_sum);
                r.out_green = mix_lane(p.src_green, p.dst_green, sa, da, weight_sum);
                r.out_blue  = mix_lane(p.src_blue,  p.dst_blue,  sa, da, weight_sum);
                r.out_alpha = 8'(weight_sum / FULL_SCALE);
            end
            return r;
        endfunction

        function void note_pair(pixel_pair_t p);
            owed_pixels.push_back(composite(p));
        endfunction

        function void compare_lane(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want)
            begin
                $error("%s mismatch: expected %0d, actual %0d", name, want, got);
                error_count++;
            end
        endfunction

        function void check_pixel(blend_pixel_t got);
            blend_pixel_t want;
            if (owed_pixels.size() == 0)
            begin
                $error("unexpected blend beat: out_red %0d out_green %0d out_blue %0d out_alpha %0d",
                       got.out_red, got.out_green, got.out_blue, got.out_alpha);
                error_count++;
                return;
            end
            want = owed_pixels.pop_front();
            compare_lane("out_red",   want.out_red,   got.out_red);
            compare_lane("out_green", want.out_green, got.out_green);
            compare_lane("out_blue",  want.out_blue,  got.out_blue);
            compare_lane("out_alpha", want.out_alpha, got.out_alpha);
        endfunction

        function int unsigned pending_count();
            return owed_pixels.size();
        endfunction
    endclass

    logic         clk;
    logic         rst_n;
    logic         pix_valid;
    logic         pix_ready;
    pixel_pair_t  pix;
    logic         blend_valid;
    logic         blend_ready;
    blend_pixel_t blend;

    blend_scoreboard blend_check = new();

    // Idling controls of the current phase, set just after a rising edge; the receiver counts hold_left down.
    int unsigned sender_idle_pct;
    int unsigned receiver_stall_pct;
    int unsigned hold_left;

    rgba8_over_alpha_blend_unit u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .pix_valid   (pix_valid),
        .pix_ready   (pix_ready),
        .pix         (pix),
        .blend_valid (blend_valid),
        .blend_ready (blend_ready),
        .blend       (blend)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Watchdog for a hung run.
    initial
    begin
        #(12 * WATCHDOG_CYCLES);
        $display("[FAIL] regression broken");
        $finish;
    end

    // Receiver: random stalls, plus a long hold-off when a phase asks for one.
    initial
    begin
        blend_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                blend_ready <= 1'b0;
                hold_left = hold_left - 1;
            end
            else
            begin
                blend_ready <= ($urandom_range(99) >= receiver_stall_pct);
            end
        end
    end

    // Beat monitor on both channels.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pix_valid && pix_ready)
                blend_check.note_pair(pix);
            if (blend_valid && blend_ready)
                blend_check.check_pixel(blend);
        end
    end

    // Called just after a rising edge, so the negedge processes see a stable value.
    task automatic start_phase(int unsigned idle_pct, int unsigned stall_pct,
                               int unsigned hold);
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        hold_left          = hold;
    endtask

    // Offers one pair after a random gap and returns just after the edge that takes it.
    task automatic send_pair(pixel_pair_t p);
        @(negedge clk);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            pix_valid <= 1'b0;
            @(negedge clk);
        end
        pix_valid <= 1'b1;
        pix       <= p;
        do
            @(posedge clk);
        while (!pix_ready);
    endtask

    function automatic pixel_pair_t make_pair(logic [7:0] sr, logic [7:0] sg,
                                              logic [7:0] sbl, logic [7:0] sa,
                                              logic [7:0] dr, logic [7:0] dg,
                                              logic [7:0] dbl, logic [7:0] da);
        pixel_pair_t p;
        p.src_red   = sr;
        p.src_green = sg;
        p.src_blue  = sbl;
        p.src_alpha = sa;
        p.dst_red   = dr;
        p.dst_green = dg;
        p.dst_blue  = dbl;
        p.dst_alpha = da;
        return p;
    endfunction

    // Alphas lean toward the transparent and opaque ends, where the math is special.
    function automatic logic [7:0] random_alpha();
        case ($urandom_range(9))
            0:       return 8'd0;
            1:       return 8'd255;
            2:       return ($urandom_range(1) != 0) ? 8'd1 : 8'd254;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [7:0] random_color();
        case ($urandom_range(19))
            0, 1, 2: return 8'd0;
            3, 4, 5: return 8'd255;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic pixel_pair_t random_pair();
        return make_pair(random_color(), random_color(), random_color(), random_alpha(),
                         random_color(), random_color(), random_color(), random_alpha());
    endfunction

    task automatic run_random_phase(int unsigned idle_pct, int unsigned stall_pct,
                                    int unsigned hold);
        start_phase(idle_pct, stall_pct, hold);
        repeat (PHASE_ITEMS)
            send_pair(random_pair());
    endtask

    // Main sequence.
    initial
    begin
        rst_n       = 1'b0;
        pix_valid   = 1'b0;
        pix         = '0;
        start_phase(0, 0, 0);
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed pairs: transparent and opaque corners, tiny alphas, bit patterns.
        start_phase(0, 0, 0);
        send_pair(make_pair(8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0));
        send_pair(make_pair(8'd255, 8'd255, 8'd255, 8'd0,   8'd255, 8'd255, 8'd255, 8'd0));
        send_pair(make_pair(8'hAA,  8'h55,  8'hF0,  8'd0,   8'h0F,  8'hCC,  8'h33,  8'd0));
        send_pair(make_pair(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255));
        send_pair(make_pair(8'd10,  8'd200, 8'd77,  8'd255, 8'd90,  8'd3,   8'd250, 8'd255));
        send_pair(make_pair(8'd10,  8'd200, 8'd77,  8'd255, 8'd90,  8'd3,   8'd250, 8'd0));
        send_pair(make_pair(8'd10,  8'd200, 8'd77,  8'd0,   8'd90,  8'd3,   8'd250, 8'd255));
        send_pair(make_pair(8'd255, 8'd0,   8'd128, 8'd0,   8'd1,   8'd254, 8'd127, 8'd1));
        send_pair(make_pair(8'd255, 8'd0,   8'd128, 8'd1,   8'd1,   8'd254, 8'd127, 8'd0));
        send_pair(make_pair(8'd255, 8'd255, 8'd255, 8'd1,   8'd0,   8'd0,   8'd0,   8'd1));
        send_pair(make_pair(8'd0,   8'd0,   8'd0,   8'd254, 8'd255, 8'd255, 8'd255, 8'd255));
        send_pair(make_pair(8'd255, 8'd255, 8'd255, 8'd254, 8'd0,   8'd0,   8'd0,   8'd1));
        send_pair(make_pair(8'd200, 8'd100, 8'd50,  8'd128, 8'd50,  8'd100, 8'd200, 8'd127));
        send_pair(make_pair(8'd255, 8'd255, 8'd255, 8'd128, 8'd0,   8'd0,   8'd0,   8'd255));
        send_pair(make_pair(8'd0,   8'd0,   8'd0,   8'd128, 8'd255, 8'd255, 8'd255, 8'd255));
        send_pair(make_pair(8'hAA,  8'hAA,  8'hAA,  8'hAA,  8'h55,  8'h55,  8'h55,  8'h55));
        send_pair(make_pair(8'h55,  8'h55,  8'h55,  8'h55,  8'hAA,  8'hAA,  8'hAA,  8'hAA));
        send_pair(make_pair(8'd1,   8'd2,   8'd4,   8'd8,   8'd16,  8'd32,  8'd64,  8'd128));
        send_pair(make_pair(8'd255, 8'd255, 8'd255, 8'd255, 8'd0,   8'd0,   8'd0,   8'd0));
        send_pair(make_pair(8'd0,   8'd0,   8'd0,   8'd0,   8'd255, 8'd255, 8'd255, 8'd255));

        // Random pairs under each idling pattern, then a long receiver hold-off.
        run_random_phase(0, 0, 0);
        run_random_phase(80, 0, 0);
        run_random_phase(0, 80, 0);
        run_random_phase(30, 30, 0);
        run_random_phase(0, 0, HOLD_CYCLES);

        // Drain with the receiver always ready.
        start_phase(0, 0, 0);
        @(negedge clk);
        pix_valid <= 1'b0;
        while (blend_check.pending_count() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (blend_check.error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
